### rtl/bfa_pkg.sv
// package: sequencer states, request kinds, divider request and response types
`default_nettype none
package bfa_pkg;

  localparam int DIV_W = 32;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FREE    = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_RESERVE = 2'd3;

  typedef enum logic [3:0] {
    ST_FILL,
    ST_IDLE,
    ST_DIV_A,
    ST_DIV_L,
    ST_PREP_END,
    ST_PREP_CNT,
    ST_DIV_W,
    ST_RUN,
    ST_FIX_RD,
    ST_FIX_WR,
    ST_ALLOC,
    ST_ALLOC_MUL,
    ST_DONE
  } bfa_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

### rtl/bfa_if.sv
// interfaces: request, result and configuration channels
`default_nettype none
interface bfa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] address;
  logic [31:0] length;
  modport source(output valid, kind, address, length, input ready);
  modport sink(input valid, kind, address, length, output ready);
endinterface

interface bfa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_address;
  logic        ok;
  logic [15:0] used_count;
  modport source(output valid, block_address, ok, used_count, input ready);
  modport sink(input valid, block_address, ok, used_count, output ready);
endinterface

interface bfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] total_blocks;
  modport source(output valid, total_blocks, input ready);
  modport sink(input valid, total_blocks, output ready);
endinterface
`default_nettype wire

### rtl/bfa_div.sv
// power-of-two divider: shift and mask, result registered in the cycle after start
`default_nettype none
module bfa_div import bfa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(DIV_W);

  logic             done;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [CW-1:0]    shift;
  logic [DIV_W-1:0] mask;

  // the divisor is a power of two, its set bit gives the shift
  always_comb begin
    shift = '0;
    for (int b = 0; b < DIV_W; b++) begin
      if (req.divisor[b]) begin
        shift = CW'(b);
      end
    end
    mask = req.divisor - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req.start;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend >> shift;
      rem <= req.dividend & mask;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule
`default_nettype wire

### rtl/bitmap_frame_allocator.sv
// bitmap frame allocator: usage map memory, request sequencer and result register
//
// request channel carries kind, address and length; one result beat comes back per
// request on the result channel; the cfg channel writes total_blocks.
// one request is worked at a time; the result sits in an output register, so a
// stalled receiver holds only that beat and the next request can be taken meanwhile;
// that request then waits in its last state until the held beat is taken.
// alloc reads the map one word per cycle, up to the first word with a clear bit or
// over all whole words below total_blocks, and marks the first clear bit it finds used.
// free clears one block unless it lies past the end; release and reserve clear or set,
// word by word, every block of the region below total_blocks, and release then sets
// block 0 back to used.
// block and word positions come from shifts and masks, BLOCK_BYTES and WORD_BITS being
// powers of two.
// reset and every total_blocks write start a fill pass that sets all MAP_WORDS map words
// (1024 at the default size) to used; no request is taken during it.
// used_count saturates at 0 and 0xffff.
`default_nettype none
module bitmap_frame_allocator import bfa_pkg::*; #(
  parameter int MAX_BLOCKS  = 32768,
  parameter int BLOCK_BYTES = 4096,
  parameter int WORD_BITS   = 32
) (
  input  logic             clk,
  input  logic             rst,
  bfa_in_if.sink           request,
  bfa_out_if.source        result,
  bfa_cfg_if.sink          cfg
);

  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int OW = $clog2(WORD_BITS);
  localparam int BW = $clog2(WORD_BITS + 1);
  localparam logic [WORD_BITS-1:0] WORD_FULL = {WORD_BITS{1'b1}};
  localparam logic [WORD_BITS-1:0] WORD_ONE  = {{(WORD_BITS-1){1'b0}}, 1'b1};
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [31:0] BB32 = 32'(BLOCK_BYTES);
  localparam logic [31:0] WB32 = 32'(WORD_BITS);

  bfa_state_t state, state_next;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] mem_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [WORD_BITS-1:0] mem_wd;
  logic [AW-1:0]        mem_ra;

  logic [AW-1:0]  fill_idx;
  logic [15:0]    total_q;
  logic [15:0]    used_q;
  logic           p_valid;
  logic           out_valid;

  logic [1:0]     kind_q;
  logic [31:0]    len_q;
  logic [31:0]    start_q;
  logic [31:0]    lenq_q;
  logic [15:0]    end_q;
  logic [15:0]    remaining_q;
  logic [AW-1:0]  rd_idx;
  logic [OW-1:0]  lo_q;
  logic [15:0]    base_q;
  logic [AW-1:0]  p_idx;
  logic [WORD_BITS-1:0] p_mask;
  logic [15:0]    p_base;
  logic [15:0]    blk_q;
  logic [31:0]    res_addr;
  logic           res_ok;
  logic [31:0]    out_addr;
  logic           out_ok;
  logic [15:0]    out_used;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic           accept;
  logic           issue_run;
  logic           issue_alloc;
  logic           scan_ok;
  logic           found;
  logic           set_v;
  logic [BW-1:0]  avail;
  logic [BW-1:0]  k;
  logic [WORD_BITS-1:0] run_mask;
  logic [WORD_BITS-1:0] run_wb;
  logic [OW-1:0]  zero_pos;
  logic [15:0]    cfg_total;
  logic [32:0]    end_sum;
  logic [15:0]    end_c;
  logic [15:0]    n_comb;
  logic [16:0]    used_sum;
  logic [15:0]    used_region;

  bfa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // datapath terms
  always_comb begin
    accept    = request.valid && request.ready;
    set_v     = kind_q == KIND_RESERVE;
    scan_ok   = ({1'b0, base_q} + 17'(WORD_BITS)) <= {1'b0, total_q};
    found     = p_valid && (mem_q != WORD_FULL);
    issue_run = (state == ST_RUN) && (remaining_q != 16'd0);
    issue_alloc = (state == ST_ALLOC) && !found && scan_ok;

    avail    = BW'(WORD_BITS) - BW'(lo_q);
    k        = (remaining_q < 16'(avail)) ? remaining_q[BW-1:0] : avail;
    run_mask = (WORD_FULL >> (BW'(WORD_BITS) - k)) << lo_q;
    run_wb   = set_v ? (mem_q | p_mask) : (mem_q & ~p_mask);

    cfg_total = (32'(cfg.total_blocks) > 32'(MAX_BLOCKS)) ? 16'(MAX_BLOCKS)
                                                          : cfg.total_blocks;

    end_sum = {1'b0, start_q} + {1'b0, lenq_q};
    end_c   = (end_sum > {17'd0, total_q}) ? total_q : end_sum[15:0];
    n_comb  = ({16'd0, end_q} > start_q) ? (end_q - start_q[15:0]) : 16'd0;

    used_sum = {1'b0, used_q} + {1'b0, n_comb};
    if (set_v) begin
      used_region = used_sum[16] ? COUNT_MAX : used_sum[15:0];
    end else begin
      used_region = (used_q > n_comb) ? (used_q - n_comb) : 16'd0;
    end
  end

  // first clear bit of the word just read
  always_comb begin
    zero_pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!mem_q[b]) begin
        zero_pos = OW'(b);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    if (cfg.valid) begin
      state_next = ST_FILL;
    end else begin
      case (state)
        ST_FILL: begin
          if (fill_idx == LAST_WORD) state_next = ST_IDLE;
        end
        ST_IDLE: begin
          if (request.valid) begin
            state_next = (request.kind == KIND_ALLOC) ? ST_ALLOC : ST_DIV_A;
          end
        end
        ST_DIV_A: begin
          if (div_rsp.done) state_next = (kind_q == KIND_FREE) ? ST_PREP_END : ST_DIV_L;
        end
        ST_DIV_L: begin
          if (div_rsp.done) state_next = ST_PREP_END;
        end
        ST_PREP_END: state_next = ST_PREP_CNT;
        ST_PREP_CNT: begin
          if (n_comb != 16'd0) begin
            state_next = ST_DIV_W;
          end else begin
            state_next = (kind_q == KIND_RELEASE) ? ST_FIX_RD : ST_DONE;
          end
        end
        ST_DIV_W: begin
          if (div_rsp.done) state_next = ST_RUN;
        end
        ST_RUN: begin
          if (remaining_q == 16'd0 && !p_valid) begin
            state_next = (kind_q == KIND_RELEASE) ? ST_FIX_RD : ST_DONE;
          end
        end
        ST_FIX_RD: state_next = ST_FIX_WR;
        ST_FIX_WR: state_next = ST_DONE;
        ST_ALLOC: begin
          if (found) begin
            state_next = ST_ALLOC_MUL;
          end else if (!scan_ok && !p_valid) begin
            state_next = ST_DONE;
          end
        end
        ST_ALLOC_MUL: state_next = ST_DONE;
        ST_DONE: begin
          if (!out_valid || result.ready) state_next = ST_IDLE;
        end
        default: state_next = ST_FILL;
      endcase
    end
  end

  // sequencer outputs: handshakes, memory ports, divider start
  always_comb begin
    request.ready = state == ST_IDLE;
    cfg.ready     = 1'b1;

    mem_we = 1'b0;
    mem_wa = p_idx;
    mem_wd = run_wb;
    mem_ra = rd_idx;
    case (state)
      ST_FILL: begin
        mem_we = 1'b1;
        mem_wa = fill_idx;
        mem_wd = WORD_FULL;
      end
      ST_RUN: begin
        mem_we = p_valid;
      end
      ST_ALLOC: begin
        mem_we = found;
        mem_wd = mem_q | (WORD_ONE << zero_pos);
      end
      ST_FIX_RD: begin
        mem_ra = '0;
      end
      ST_FIX_WR: begin
        mem_we = 1'b1;
        mem_wa = '0;
        mem_wd = mem_q | WORD_ONE;
      end
      default: mem_we = 1'b0;
    endcase

    div_req.start = (state_next != state) &&
                    (state_next == ST_DIV_A || state_next == ST_DIV_L ||
                     state_next == ST_DIV_W);
    div_req.divisor = (state_next == ST_DIV_W) ? WB32 : BB32;
    case (state_next)
      ST_DIV_A: div_req.dividend = request.address;
      ST_DIV_L: div_req.dividend = len_q;
      default:  div_req.dividend = start_q;
    endcase
  end

  // usage map
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      fill_idx  <= '0;
      total_q   <= '0;
      used_q    <= '0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      p_valid <= issue_run || issue_alloc;
      if (cfg.valid) begin
        total_q  <= cfg_total;
        used_q   <= cfg_total;
        fill_idx <= '0;
      end else begin
        if (state == ST_FILL) fill_idx <= fill_idx + 1'b1;
        if (state == ST_PREP_CNT) used_q <= used_region;
        if (state == ST_ALLOC_MUL && used_q != COUNT_MAX) used_q <= used_q + 16'd1;
      end
      if (state == ST_DONE && state_next == ST_IDLE) out_valid <= 1'b1;
      else if (result.valid && result.ready) out_valid <= 1'b0;
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q   <= request.kind;
      len_q    <= request.length;
      res_addr <= '0;
      res_ok   <= 1'b1;
      rd_idx   <= '0;
      base_q   <= '0;
    end
    if (state == ST_DIV_A && div_rsp.done) begin
      start_q <= div_rsp.quotient;
      lenq_q  <= 32'd1;
    end
    if (state == ST_DIV_L && div_rsp.done) lenq_q <= div_rsp.quotient;
    if (state == ST_PREP_END) end_q <= end_c;
    if (state == ST_PREP_CNT) remaining_q <= n_comb;
    if (state == ST_DIV_W && div_rsp.done) begin
      rd_idx <= div_rsp.quotient[AW-1:0];
      lo_q   <= div_rsp.remainder[OW-1:0];
    end
    if (issue_run) begin
      p_idx       <= rd_idx;
      p_mask      <= run_mask;
      remaining_q <= remaining_q - 16'(k);
      lo_q        <= '0;
      rd_idx      <= rd_idx + 1'b1;
    end
    if (issue_alloc) begin
      p_idx  <= rd_idx;
      p_base <= base_q;
      base_q <= base_q + 16'(WORD_BITS);
      rd_idx <= rd_idx + 1'b1;
    end
    if (state == ST_ALLOC && found) blk_q <= p_base + 16'(zero_pos);
    if (state == ST_ALLOC && state_next == ST_DONE) res_ok <= 1'b0;
    if (state == ST_ALLOC_MUL) res_addr <= 32'(blk_q) * BB32;
    if (state == ST_DONE && state_next == ST_IDLE) begin
      out_addr <= res_addr;
      out_ok   <= res_ok;
      out_used <= used_q;
    end
  end

  assign result.valid         = out_valid;
  assign result.block_address = out_addr;
  assign result.ok            = out_ok;
  assign result.used_count    = out_used;

endmodule
`default_nettype wire
